>>> hdl/ctg_pkg.sv
// Shared types, constants and coefficient table of the circle trajectory generator.
package ctg_pkg;

    // Phase accumulator width, in fractions of one turn.
    localparam int PHASE_BITS = 32;

    // Field widths.
    localparam int PERIOD_W = 14;
    localparam int RADIUS_W = 29;
    localparam int MAXSPD_W = 20;
    localparam int RAMP_W   = 26;
    localparam int RUN_W    = 30;
    localparam int POS_W    = 32;
    localparam int CFG_W    = 30;
    localparam int SPEED_W  = MAXSPD_W + 8;
    localparam int INC_W    = PERIOD_W + MAXSPD_W + 8;
    localparam int NUM_W    = PERIOD_W + SPEED_W + 10;
    localparam int Q_W      = 31;

    // Serial multiplier: one multiplier bit per cycle.
    localparam int MUL_A_W   = 42;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = 64;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Serial restoring divider: one quotient bit per cycle.
    localparam int DIV_W   = NUM_W + PHASE_BITS;
    localparam int DEN_W   = 60;
    localparam int STEP_W  = $clog2(DIV_W + 1);
    localparam int QUO_W   = (INC_W > PHASE_BITS) ? INC_W : PHASE_BITS;

    localparam logic [Q_W-1:0]     Q30_ONE   = Q_W'(1) << 30;
    localparam logic [MUL_P_W-1:0] Q30_HALF  = MUL_P_W'(1) << 29;
    localparam logic [MUL_P_W-1:0] Q31_HALF  = MUL_P_W'(1) << 30;
    localparam logic [31:0]        PI_Q30    = 32'hC90F_DAA2;
    localparam logic [30:0]        PHASE_DEN = 31'd1608495439;
    localparam logic [31:0]        OCT_BIAS  = 32'h2000_0000;

    // Index of the last sine term, of the first cosine term and of the last cosine term.
    localparam logic [3:0] K_SIN_LAST = 4'd4;
    localparam logic [3:0] K_COS_FIRST = 4'd5;
    localparam logic [3:0] K_COS_LAST = 4'd9;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_MAX_SPEED = 2'd1,
        REG_RAMP_TIME = 2'd2,
        REG_RUN_TIME = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Horner divisors: sine terms first, then cosine terms.
    function automatic logic [6:0] poly_div(input logic [3:0] k);
        logic [6:0] d;
        case (k)
            4'd0: d = 7'd110;
            4'd1: d = 7'd72;
            4'd2: d = 7'd42;
            4'd3: d = 7'd20;
            4'd4: d = 7'd6;
            4'd5: d = 7'd90;
            4'd6: d = 7'd56;
            4'd7: d = 7'd30;
            4'd8: d = 7'd12;
            4'd9: d = 7'd2;
            default: d = 7'd1;
        endcase
        return d;
    endfunction

endpackage

>>> hdl/ctg_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module ctg_mul import ctg_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  mul_req_t           req,
    output unit_stat_t         stat,
    output logic [MUL_P_W-1:0] prod
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MUL_P_W-1:0]   a_reg, a_next;
    logic [MUL_B_W-1:0]   b_reg, b_next;
    logic [MUL_P_W-1:0]   acc_reg, acc_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = MUL_P_W'(req.a);
            b_next    = req.b;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

>>> hdl/ctg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle from a left-aligned numerator.
module ctg_div import ctg_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    output unit_stat_t       stat,
    output logic [QUO_W-1:0] quo
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [DIV_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DEN_W:0]    trial;

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        steps_next = steps_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        trial      = {rem_reg, num_reg[DIV_W-1]};
        if (req.start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            steps_next = req.steps;
            num_next   = req.num;
            den_next   = req.den;
            rem_next   = '0;
            quo_next   = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = DEN_W'(trial);
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            num_next = num_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == steps_reg - 1'b1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        steps_reg <= steps_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

>>> hdl/circle_trajectory_generator.sv
// Top level of the circle trajectory generator: sequencer, state and output register.
//
// Each input beat (s_valid/s_ready) carries the tick period and the commanded y and z.
// The block answers with exactly one result beat (m_valid/m_ready) holding target y,
// target z and the finished flag. Configuration registers are written through
// cfg_wr_en/cfg_wr_index/cfg_wr_data, one write per cycle; the user must write them
// only while the block is idle, as the block itself does not enforce it. The block
// takes one beat at a time. The work is done by one shared bit-serial multiplier
// (17 products) and one bit-serial divider (ramp step, phase step and ten series
// terms). Reset clears the time, speed, phase and start point, and loads the
// register defaults. A result waits in the output register while the receiver
// stalls; the next input beat is already taken and worked on, and its result is
// held back until the pending one has gone.
module circle_trajectory_generator import ctg_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [PERIOD_W-1:0]     s_period_us,
    input  logic signed [POS_W-1:0] s_commanded_y,
    input  logic signed [POS_W-1:0] s_commanded_z,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_target_y,
    output logic signed [POS_W-1:0] m_target_z,
    output logic                    m_finished,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_wr_index,
    input  logic [CFG_W-1:0]        cfg_wr_data
);

    typedef enum logic [18:0] {
        ST_IDLE     = 19'h00001,
        ST_INC_MUL  = 19'h00002,
        ST_INC_DIV  = 19'h00004,
        ST_SPD1     = 19'h00008,
        ST_SPD2     = 19'h00010,
        ST_NUM_MUL  = 19'h00020,
        ST_NUM_MUL2 = 19'h00040,
        ST_DEN_MUL  = 19'h00080,
        ST_PH_DIV   = 19'h00100,
        ST_PH_RED   = 19'h00200,
        ST_XM_MUL   = 19'h00400,
        ST_X2_MUL   = 19'h00800,
        ST_P_DIV    = 19'h01000,
        ST_P_MUL    = 19'h02000,
        ST_S_MUL    = 19'h04000,
        ST_QUAD     = 19'h08000,
        ST_OFF_Y    = 19'h10000,
        ST_OFF_Z    = 19'h20000,
        ST_OUT      = 19'h40000
    } state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]     period;
        logic [31:0]             elapsed;
        logic [SPEED_W-1:0]      speed;
        logic [PHASE_BITS-1:0]   phase;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] start_z;
        logic [INC_W-1:0]        inc;
        logic [INC_W:0]          s1;
        logic [NUM_W-1:0]        num;
        logic [1:0]              quad;
        logic                    neg;
        logic [Q_W-1:0]          x;
        logic [Q_W-1:0]          x2;
        logic [Q_W-1:0]          u;
        logic [Q_W-1:0]          sn;
        logic [3:0]              k;
        logic signed [31:0]      sv;
        logic signed [31:0]      cv;
        logic [Q_W-1:0]          dy;
    } dp_t;

    state_t state_reg, state_next;
    dp_t    dp_reg, dp_next;

    logic [RADIUS_W-1:0] radius_reg;
    logic [MAXSPD_W-1:0] max_speed_reg;
    logic [RAMP_W-1:0]   ramp_reg;
    logic [RUN_W-1:0]    run_reg;

    logic                    out_valid_reg, out_valid_next;
    logic signed [POS_W-1:0] ty_reg, ty_next;
    logic signed [POS_W-1:0] tz_reg, tz_next;
    logic                    fin_reg, fin_next;

    mul_req_t           mul_req;
    unit_stat_t         mul_stat;
    logic [MUL_P_W-1:0] mul_prod;
    div_req_t           div_req;
    unit_stat_t         div_stat;
    logic [QUO_W-1:0]   div_quo;

    logic [32:0]          el_sum;
    logic [SPEED_W-1:0]   maxq;
    logic [INC_W:0]       s2;
    logic [31:0]          ph32, oct_sum, rr, mag32;
    logic [MUL_P_W-1:0]   rnd30, rnd31;
    logic [Q_W-1:0]       mq;
    logic [Q_W-1:0]       u_new;
    logic signed [31:0]   sxs, cxs, sv_n, cv_n;
    logic signed [33:0]   ysum, zsum, dz;
    logic                 out_free;

    ctg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .stat    (mul_stat),
        .prod    (mul_prod)
    );

    ctg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat),
        .quo     (div_quo)
    );

    assign maxq     = {max_speed_reg, 8'b0};
    assign rnd30    = mul_prod + Q30_HALF;
    assign rnd31    = mul_prod + Q31_HALF;
    assign mq       = rnd30[60:30];
    assign u_new    = Q30_ONE - Q_W'(div_quo);
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        dp_next        = dp_reg;
        mul_req        = '0;
        div_req        = '0;
        out_valid_next = out_valid_reg;
        ty_next        = ty_reg;
        tz_next        = tz_reg;
        fin_next       = fin_reg;
        el_sum         = {1'b0, dp_reg.elapsed} + 33'(s_period_us);
        s2             = dp_reg.s1;
        ph32           = 32'(dp_reg.phase) << (32 - PHASE_BITS);
        oct_sum        = ph32 + OCT_BIAS;
        rr             = ph32 - {oct_sum[31:30], 30'b0};
        mag32          = rr[31] ? (32'd0 - rr) : rr;
        sxs            = dp_reg.neg ? -32'(dp_reg.sn) : 32'(dp_reg.sn);
        cxs            = 32'(dp_reg.u);
        sv_n           = sxs;
        cv_n           = cxs;
        ysum           = 34'(dp_reg.start_y) + 34'(dp_reg.dy);
        dz             = (dp_reg.sv < 0) ? -34'(mq) : 34'(mq);
        zsum           = 34'(dp_reg.start_z) + dz;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dp_next.elapsed = el_sum[32] ? '1 : el_sum[31:0];
                    dp_next.period  = s_period_us;
                    if (dp_next.elapsed == '0) begin
                        dp_next.start_y = s_commanded_y;
                        dp_next.start_z = s_commanded_z;
                    end
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(max_speed_reg);
                    mul_req.b     = MUL_B_W'(s_period_us);
                    state_next    = ST_INC_MUL;
                end
            end
            ST_INC_MUL: begin
                if (mul_stat.done) begin
                    if (ramp_reg == '0) begin
                        dp_next.inc = INC_W'(maxq);
                        state_next  = ST_SPD1;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = DIV_W'({mul_prod[INC_W-9:0], 8'b0}) << (DIV_W - INC_W);
                        div_req.den   = DEN_W'(ramp_reg);
                        div_req.steps = STEP_W'(INC_W);
                        state_next    = ST_INC_DIV;
                    end
                end
            end
            ST_INC_DIV: begin
                if (div_stat.done) begin
                    dp_next.inc = INC_W'(div_quo);
                    state_next  = ST_SPD1;
                end
            end
            ST_SPD1: begin
                if (dp_reg.speed < maxq && dp_reg.elapsed < 32'(run_reg)) begin
                    dp_next.s1 = (INC_W + 1)'(dp_reg.speed) + (INC_W + 1)'(dp_reg.inc);
                end else begin
                    dp_next.s1 = (INC_W + 1)'(dp_reg.speed);
                end
                state_next = ST_SPD2;
            end
            ST_SPD2: begin
                if (dp_reg.s1 != '0 && dp_reg.elapsed > 32'(run_reg)) begin
                    s2 = (dp_reg.s1 > (INC_W + 1)'(dp_reg.inc)) ?
                         dp_reg.s1 - (INC_W + 1)'(dp_reg.inc) : '0;
                end
                dp_next.speed = (s2 > (INC_W + 1)'(maxq)) ? maxq : s2[SPEED_W-1:0];
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(dp_next.speed);
                mul_req.b     = MUL_B_W'(dp_reg.period);
                state_next    = ST_NUM_MUL;
            end
            ST_NUM_MUL: begin
                if (mul_stat.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mul_prod[MUL_A_W-1:0];
                    mul_req.b     = MUL_B_W'(1000);
                    state_next    = ST_NUM_MUL2;
                end
            end
            ST_NUM_MUL2: begin
                if (mul_stat.done) begin
                    dp_next.num   = mul_prod[NUM_W-1:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(PHASE_DEN);
                    mul_req.b     = (radius_reg == '0) ? MUL_B_W'(1) : MUL_B_W'(radius_reg);
                    state_next    = ST_DEN_MUL;
                end
            end
            ST_DEN_MUL: begin
                if (mul_stat.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'(dp_reg.num) << PHASE_BITS;
                    div_req.den   = mul_prod[DEN_W-1:0];
                    div_req.steps = STEP_W'(DIV_W);
                    state_next    = ST_PH_DIV;
                end
            end
            ST_PH_DIV: begin
                if (div_stat.done) begin
                    dp_next.phase = dp_reg.phase + div_quo[PHASE_BITS-1:0];
                    state_next    = ST_PH_RED;
                end
            end
            ST_PH_RED: begin
                // Fold the angle to the nearest quarter turn; the residual is at most 1/8 turn.
                dp_next.quad  = oct_sum[31:30];
                dp_next.neg   = rr[31];
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(PI_Q30);
                mul_req.b     = mag32;
                state_next    = ST_XM_MUL;
            end
            ST_XM_MUL: begin
                if (mul_stat.done) begin
                    dp_next.x     = rnd31[61:31];
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(dp_next.x);
                    mul_req.b     = MUL_B_W'(dp_next.x);
                    state_next    = ST_X2_MUL;
                end
            end
            ST_X2_MUL: begin
                if (mul_stat.done) begin
                    dp_next.x2    = mq;
                    dp_next.k     = '0;
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'(mq) << (DIV_W - Q_W);
                    div_req.den   = DEN_W'(poly_div('0));
                    div_req.steps = STEP_W'(Q_W);
                    state_next    = ST_P_DIV;
                end
            end
            ST_P_DIV: begin
                if (div_stat.done) begin
                    dp_next.u = u_new;
                    if (dp_reg.k == K_SIN_LAST) begin
                        mul_req.start = 1'b1;
                        mul_req.a     = MUL_A_W'(dp_reg.x);
                        mul_req.b     = MUL_B_W'(u_new);
                        state_next    = ST_S_MUL;
                    end else if (dp_reg.k == K_COS_LAST) begin
                        state_next = ST_QUAD;
                    end else begin
                        dp_next.k     = dp_reg.k + 1'b1;
                        mul_req.start = 1'b1;
                        mul_req.a     = MUL_A_W'(dp_reg.x2);
                        mul_req.b     = MUL_B_W'(u_new);
                        state_next    = ST_P_MUL;
                    end
                end
            end
            ST_P_MUL: begin
                if (mul_stat.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'(mq) << (DIV_W - Q_W);
                    div_req.den   = DEN_W'(poly_div(dp_reg.k));
                    div_req.steps = STEP_W'(Q_W);
                    state_next    = ST_P_DIV;
                end
            end
            ST_S_MUL: begin
                if (mul_stat.done) begin
                    dp_next.sn    = mq;
                    dp_next.k     = K_COS_FIRST;
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'(dp_reg.x2) << (DIV_W - Q_W);
                    div_req.den   = DEN_W'(poly_div(K_COS_FIRST));
                    div_req.steps = STEP_W'(Q_W);
                    state_next    = ST_P_DIV;
                end
            end
            ST_QUAD: begin
                case (dp_reg.quad)
                    2'd0: begin
                        sv_n = sxs;
                        cv_n = cxs;
                    end
                    2'd1: begin
                        sv_n = cxs;
                        cv_n = -sxs;
                    end
                    2'd2: begin
                        sv_n = -sxs;
                        cv_n = -cxs;
                    end
                    default: begin
                        sv_n = -cxs;
                        cv_n = sxs;
                    end
                endcase
                dp_next.sv    = sv_n;
                dp_next.cv    = cv_n;
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(radius_reg);
                mul_req.b     = 32'(33'(Q30_ONE) - 33'(cv_n));
                state_next    = ST_OFF_Y;
            end
            ST_OFF_Y: begin
                if (mul_stat.done) begin
                    dp_next.dy    = mq;
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_A_W'(radius_reg);
                    mul_req.b     = (dp_reg.sv < 0) ? 32'(-dp_reg.sv) : 32'(dp_reg.sv);
                    state_next    = ST_OFF_Z;
                end
            end
            ST_OFF_Z: begin
                if (mul_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // The multiplier is idle here, so its product still holds the z offset.
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (ysum[33:31] != 3'b000 && ysum[33:31] != 3'b111) begin
                        ty_next = ysum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end else begin
                        ty_next = ysum[31:0];
                    end
                    if (zsum[33:31] != 3'b000 && zsum[33:31] != 3'b111) begin
                        tz_next = zsum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end else begin
                        tz_next = zsum[31:0];
                    end
                    fin_next   = (33'(dp_reg.elapsed) >= 33'(run_reg) + 33'(ramp_reg));
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dp_reg        <= '0;
            out_valid_reg <= 1'b0;
            radius_reg    <= RADIUS_W'(50000000);
            max_speed_reg <= MAXSPD_W'(250000);
            ramp_reg      <= RAMP_W'(2000000);
            run_reg       <= RUN_W'(20000000);
        end else begin
            state_reg     <= state_next;
            dp_reg        <= dp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_wr_index))
                    REG_RADIUS:    radius_reg    <= cfg_wr_data[RADIUS_W-1:0];
                    REG_MAX_SPEED: max_speed_reg <= cfg_wr_data[MAXSPD_W-1:0];
                    REG_RAMP_TIME: ramp_reg      <= cfg_wr_data[RAMP_W-1:0];
                    REG_RUN_TIME:  run_reg       <= cfg_wr_data[RUN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        ty_reg  <= ty_next;
        tz_reg  <= tz_next;
        fin_reg <= fin_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = out_valid_reg;
    assign m_target_y = ty_reg;
    assign m_target_z = tz_reg;
    assign m_finished = fin_reg;

    a_speed_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SPD2) |=> (dp_reg.speed <= {max_speed_reg, 8'b0}))
        else $error("speed above its limit after the ramp update");

    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
        else $error("arithmetic unit still busy while waiting for a beat");

    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QUAD) |=> (dp_reg.cv <= 32'sh4000_0000 && dp_reg.cv >= -32'sh4000_0000
                                    && dp_reg.sv <= 32'sh4000_0000
                                    && dp_reg.sv >= -32'sh4000_0000))
        else $error("sine or cosine outside unit range");

    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat taken before the first one was worked off");

endmodule
